/* src/uhse_pkg.sv */
// Package for the universal hash set engine.
// Holds sizes, the hash prime, command codes, FSM states and the job type.
package uhse_pkg;
    localparam int NUM_BUCKETS = 256;
    localparam int WAYS        = 4;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int KEY_W       = 32;
    localparam int HASH_W      = 31;
    localparam int CNT_W       = 9;
    localparam int REM_W       = 30;
    localparam int MAG_W       = 63;
    localparam int HI_W        = MAG_W - REM_W;
    localparam int FOLD_W      = 27;
    localparam int PROD_W      = HI_W + FOLD_W;
    localparam int FOLD_STEPS  = 12;
    localparam logic [REM_W:0] HASH_PRIME = 31'd1000000007;
    // 2^30 mod prime
    localparam logic [FOLD_W-1:0] HASH_FOLD = 27'd73741817;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_ADD, F_PRIME, F_FIX, F_BKT, F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE, B_READ, B_EXEC
    } t_bstate;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0][KEY_W-1:0] keys;
    } t_row;
endpackage

/* src/uhse_front.sv */
// Front end: accepts items, folds the hash modulo the prime and divides by the
// bucket count bit-serially. Depends on uhse_pkg.
module uhse_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_cmd,
    input  logic signed [uhse_pkg::KEY_W-1:0] i_key,
    input  logic [uhse_pkg::HASH_W-1:0]    i_hash_mult,
    input  logic [uhse_pkg::HASH_W-1:0]    i_hash_offset,
    input  logic [uhse_pkg::CNT_W-1:0]     i_bucket_count,
    output logic                           o_push,
    output uhse_pkg::t_job                 o_job,
    input  logic                           i_full
);
    import uhse_pkg::*;

    t_fstate r_state, n_state;
    logic [1:0]         r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic signed [63:0] r_prod;
    logic [MAG_W-1:0]   r_dvd;
    logic               r_neg;
    logic [REM_W-1:0]   r_q;
    logic [BKT_W-1:0]   r_brem;
    logic [5:0]         r_cnt;

    logic signed [63:0] sum;
    logic [PROD_W-1:0]  fold_mul;
    logic [MAG_W-1:0]   fold;
    logic [REM_W:0]     red;
    logic [CNT_W-1:0]   bv;
    logic [CNT_W-1:0]   n_eff;
    logic               accept;

    assign o_in_stall = (r_state != F_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign sum        = r_prod + $signed({33'd0, i_hash_offset});
    assign fold_mul   = PROD_W'(r_dvd[MAG_W-1:REM_W]) * PROD_W'(HASH_FOLD);
    assign fold       = MAG_W'(fold_mul) + MAG_W'(r_dvd[REM_W-1:0]);
    assign red        = (r_dvd[REM_W:0] >= HASH_PRIME) ? r_dvd[REM_W:0] - HASH_PRIME
                                                       : r_dvd[REM_W:0];
    assign bv         = {r_brem, r_q[REM_W-1]};
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_job      = '{cmd: r_cmd, key: r_key, bucket: r_brem};

    always_comb begin
        if (i_bucket_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (i_bucket_count > CNT_W'(NUM_BUCKETS)) begin
            n_eff = CNT_W'(NUM_BUCKETS);
        end else begin
            n_eff = i_bucket_count;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_MUL;
            F_MUL:   n_state = F_ADD;
            F_ADD:   n_state = F_PRIME;
            F_PRIME: if (r_cnt == 6'd0) n_state = F_FIX;
            F_FIX:   n_state = F_BKT;
            F_BKT:   if (r_cnt == 6'd0) n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_cmd <= i_cmd;
                    r_key <= i_key;
                end
            end
            F_MUL: begin
                r_prod <= $signed({1'b0, i_hash_mult}) * $signed(r_key);
            end
            F_ADD: begin
                r_neg <= sum[63];
                r_dvd <= sum[63] ? MAG_W'(-sum) : sum[MAG_W-1:0];
                r_cnt <= 6'(FOLD_STEPS - 1);
            end
            F_PRIME: begin
                r_dvd <= fold;
                r_cnt <= r_cnt - 6'd1;
            end
            F_FIX: begin
                r_q    <= (r_neg && red[REM_W-1:0] != '0) ? REM_W'(HASH_PRIME - red)
                                                          : red[REM_W-1:0];
                r_brem <= '0;
                r_cnt  <= 6'(REM_W - 1);
            end
            F_BKT: begin
                r_q    <= {r_q[REM_W-2:0], 1'b0};
                r_brem <= (bv >= n_eff) ? BKT_W'(bv - n_eff) : bv[BKT_W-1:0];
                r_cnt  <= r_cnt - 6'd1;
            end
            default: begin
            end
        endcase
    end
endmodule

/* src/uhse_queue.sv */
// Two-entry job queue between the front end and the table back end.
// Depends on uhse_pkg.
module uhse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  uhse_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output uhse_pkg::t_job o_job
);
    import uhse_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

/* src/uhse_back.sv */
// Back end: bucket table in a row memory, lookup, update and result register.
// Depends on uhse_pkg.
module uhse_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  uhse_pkg::t_job              i_job,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic                        o_bucket_full,
    output logic [uhse_pkg::BKT_W-1:0]  o_bucket_index
);
    import uhse_pkg::*;

    t_bstate r_state, n_state;
    t_row    r_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_row_ok;
    t_job    r_job;
    t_row    r_rd;
    logic    r_rd_ok;
    logic    r_out_valid;
    logic    r_found;
    logic    r_full;
    logic [BKT_W-1:0] r_idx;

    logic [WAYS-1:0] vld;
    logic            hit;
    logic            has_free;
    logic [$clog2(WAYS)-1:0] hit_way;
    logic [$clog2(WAYS)-1:0] free_way;
    t_row            wr_row;
    logic            wr_en;

    assign o_pop          = (r_state == B_IDLE) && !i_empty && !r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_bucket_full  = r_full;
    assign o_bucket_index = r_idx;

    always_comb begin
        vld      = r_rd_ok ? r_rd.valid : '0;
        hit      = 1'b0;
        has_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (vld[w]) begin
                if (!hit && r_rd.keys[w] == r_job.key) begin
                    hit     = 1'b1;
                    hit_way = ($clog2(WAYS))'(w);
                end
            end else if (!has_free) begin
                has_free = 1'b1;
                free_way = ($clog2(WAYS))'(w);
            end
        end
        wr_row       = r_rd;
        wr_row.valid = vld;
        wr_en        = 1'b0;
        case (r_job.cmd)
            CMD_INSERT: begin
                if (!hit && has_free) begin
                    wr_row.valid[free_way] = 1'b1;
                    wr_row.keys[free_way]  = r_job.key;
                    wr_en = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (hit) begin
                    wr_row.valid[hit_way] = 1'b0;
                    wr_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (o_pop) n_state = B_READ;
            B_READ:  n_state = B_EXEC;
            B_EXEC:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_row_ok    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_EXEC) begin
                r_out_valid <= 1'b1;
                if (wr_en) r_row_ok[r_job.bucket] <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        r_rd    <= r_mem[r_job.bucket];
        r_rd_ok <= r_row_ok[r_job.bucket];
        if (r_state == B_EXEC) begin
            if (wr_en) r_mem[r_job.bucket] <= wr_row;
            r_found <= hit;
            r_full  <= (r_job.cmd == CMD_INSERT) && !hit && !has_free;
            r_idx   <= r_job.bucket;
        end
    end
endmodule

/* src/universal_hash_set_engine_unit.sv */
// Top level of the universal hash set engine: config registers, front, queue, back.
// Depends on uhse_pkg, uhse_front, uhse_queue and uhse_back.
//
//  channel | valid      | stall       | payload
//  input   | i_in_valid | o_in_stall  | i_cmd, i_key
//  output  | o_out_valid| i_out_stall | o_found, o_bucket_full, o_bucket_index
//  config  | i_cfg_we   | -           | i_cfg_idx, i_cfg_data
//
// An item passes through the front end in this order: accept, one multiply, one add,
// 12 folds of the modulo by the prime, one correction, 30 steps of the modulo
// by the bucket count and one push; a full queue extends the push.
// The back end takes each item from the queue through pop, read, update and the
// result beat, and pops no new item while a result is held. Reset is synchronous
// and clears all valid marks at once via per-row flags.
// A stalled output holds the back end; the queue lets the front end run ahead.
module universal_hash_set_engine_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_cmd,
    input  logic signed [uhse_pkg::KEY_W-1:0] i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic                             o_bucket_full,
    output logic [uhse_pkg::BKT_W-1:0]       o_bucket_index,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [uhse_pkg::HASH_W-1:0]      i_cfg_data
);
    import uhse_pkg::*;

    localparam logic [1:0] REG_MULT   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_BCOUNT = 2'd2;

    logic [HASH_W-1:0] r_mult;
    logic [HASH_W-1:0] r_offset;
    logic [CNT_W-1:0]  r_bcount;
    logic push, pop, full, empty;
    t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult   <= HASH_W'(1);
            r_offset <= '0;
            r_bcount <= CNT_W'(NUM_BUCKETS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MULT:   r_mult   <= i_cfg_data;
                REG_OFFSET: r_offset <= i_cfg_data;
                REG_BCOUNT: r_bcount <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uhse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_hash_mult    (r_mult),
        .i_hash_offset  (r_offset),
        .i_bucket_count (r_bcount),
        .o_push         (push),
        .o_job          (job_in),
        .i_full         (full)
    );

    uhse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    uhse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (job_out),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_bucket_full  (o_bucket_full),
        .o_bucket_index (o_bucket_index)
    );
endmodule

/* tb/tb_universal_hash_set_engine_unit.sv */
// Self-checking testbench for universal_hash_set_engine_unit: finds, inserts and deletes
// under several hash settings, checked against an in-bench hash set with random idling.
// Depends on uhse_pkg and the RTL of the engine.
`timescale 1ns / 1ps

module tb_universal_hash_set_engine_unit;
    import uhse_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        bit       found;
        bit       full;
        bit [7:0] bucket;
    } t_lookup;

    class hash_set_scoreboard;
        bit [30:0]   mult = 1;
        bit [30:0]   offs = 0;
        bit [8:0]    nbkt = 256;
        bit          valid [NUM_BUCKETS*WAYS];
        logic [31:0] keys [NUM_BUCKETS*WAYS];
        t_lookup     pending_lookups[$];
        int          errors = 0;

        function void set_reg(int idx, bit [30:0] data);
            if (idx == 0) mult = data;
            else if (idx == 1) offs = data;
            else if (idx == 2) nbkt = data[8:0];
        endfunction

        function bit [7:0] bucket_of(logic signed [31:0] key);
            longint k;
            longint t;
            longint r;
            longint n;
            k = key;
            t = longint'({1'b0, mult}) * k + longint'({1'b0, offs});
            r = t % longint'(HASH_PRIME);
            if (r < 0) r += longint'(HASH_PRIME);
            n = nbkt;
            if (n == 0) n = 1;
            if (n > NUM_BUCKETS) n = NUM_BUCKETS;
            return 8'(r % n);
        endfunction

        function void note_op(t_cmd cmd, logic signed [31:0] key);
            t_lookup e;
            int base;
            int hit;
            int free_way;
            e.bucket = bucket_of(key);
            e.full = 0;
            base = e.bucket * WAYS;
            hit = -1;
            free_way = -1;
            for (int w = 0; w < WAYS; w++) begin
                if (valid[base+w]) begin
                    if (hit < 0 && keys[base+w] == key) hit = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            if (cmd == CMD_INSERT && hit < 0) begin
                if (free_way >= 0) begin
                    valid[base+free_way] = 1;
                    keys[base+free_way] = key;
                end else begin
                    e.full = 1;
                end
            end else if (cmd == CMD_DELETE && hit >= 0) begin
                valid[base+hit] = 0;
            end
            e.found = (hit >= 0);
            pending_lookups.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(bit found, bit full, bit [7:0] bucket);
            t_lookup e;
            if (pending_lookups.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = pending_lookups.pop_front();
            if (found !== e.found)
                report($sformatf("found %0b, expected %0b", found, e.found));
            if (full !== e.full)
                report($sformatf("bucket_full %0b, expected %0b", full, e.full));
            if (bucket !== e.bucket)
                report($sformatf("bucket_index %0d, expected %0d", bucket, e.bucket));
        endtask
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_in_valid = 0;
    logic              o_in_stall;
    logic [1:0]        i_cmd = CMD_FIND;
    logic signed [31:0] i_key = 0;
    logic              o_out_valid;
    logic              i_out_stall = 0;
    logic              o_found;
    logic              o_bucket_full;
    logic [BKT_W-1:0]  o_bucket_index;
    logic              i_cfg_we = 0;
    logic [1:0]        i_cfg_idx = 0;
    logic [HASH_W-1:0] i_cfg_data = 0;

    hash_set_scoreboard hset = new();
    int  cycle_cnt = 0;
    bit  no_idle = 0;
    int  stall_len = 0;
    logic signed [31:0] key_pool [32];

    universal_hash_set_engine_unit DUT (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) hset.note_op(t_cmd'(i_cmd), i_key);
            if (o_out_valid && !i_out_stall)
                hset.check_result(o_found, o_bucket_full, o_bucket_index);
        end
    end

    function int pick_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // hold stall for random stretches
    always @(posedge i_clk) begin
        if (no_idle) begin
            i_out_stall <= 0;
            stall_len <= 0;
        end else if (stall_len == 0) begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_len <= pick_gap() + 1;
        end else begin
            stall_len <= stall_len - 1;
        end
    end

    task send_op(t_cmd cmd, logic signed [31:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_cmd <= cmd;
        i_key <= key;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task drain();
        i_in_valid <= 0;
        while (hset.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task cfg_write(int idx, bit [30:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx[1:0];
        i_cfg_data <= data;
        @(posedge i_clk);
        hset.set_reg(idx, data);
    endtask

    task set_hash(bit [30:0] a, bit [30:0] b, bit [30:0] n);
        drain();
        cfg_write(0, a);
        cfg_write(1, b);
        cfg_write(2, n);
        i_cfg_we <= 0;
    endtask

    task run_random(int count);
        t_cmd cmd;
        logic signed [31:0] key;
        int r;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40) cmd = CMD_INSERT;
            else if (r < 70) cmd = CMD_FIND;
            else if (r < 95) cmd = CMD_DELETE;
            else cmd = CMD_NONE;
            if ($urandom_range(0, 9) < 6) key = key_pool[$urandom_range(0, 31)];
            else key = $urandom();
            send_op(cmd, key);
        end
        no_idle = 0;
    endtask

    initial begin
        for (int i = 0; i < 32; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_op(CMD_FIND, 0);
        send_op(CMD_INSERT, 0);
        send_op(CMD_FIND, 0);
        send_op(CMD_INSERT, 0);
        send_op(CMD_INSERT, -1);
        send_op(CMD_INSERT, 32'sh8000_0000);
        send_op(CMD_INSERT, 32'sh7fff_ffff);
        send_op(CMD_DELETE, 12345);
        send_op(CMD_DELETE, -1);
        send_op(CMD_FIND, -1);
        send_op(CMD_NONE, 0);
        send_op(CMD_NONE, 777);
        send_op(CMD_FIND, 32'sh8000_0000);

        // one bucket: fill every way, then overflow
        set_hash(0, 0, 1);
        for (int i = 0; i < WAYS + 2; i++) send_op(CMD_INSERT, 100 + i);
        send_op(CMD_FIND, 100);
        send_op(CMD_DELETE, 101);
        send_op(CMD_INSERT, 200);
        run_random(200);

        set_hash(31'h7fff_ffff, 31'h7fff_ffff, 256);
        run_random(300);
        set_hash(31'($urandom()), 31'($urandom()), 0);
        run_random(150);
        set_hash(31'($urandom()), 31'($urandom()), 511);
        run_random(250);
        set_hash(31'($urandom()), 31'($urandom()), 31'($urandom_range(2, 8)));
        run_random(300);
        set_hash(31'($urandom()), 31'($urandom()), 31'($urandom_range(257, 511)));
        run_random(200);
        set_hash(31'($urandom()), 0, 31'($urandom_range(9, 255)));
        run_random(300);

        drain();
        if (hset.errors == 0 && hset.pending_lookups.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* universal_hash_set_engine_unit.f */
src/uhse_pkg.sv
src/uhse_front.sv
src/uhse_queue.sv
src/uhse_back.sv
src/universal_hash_set_engine_unit.sv
tb/tb_universal_hash_set_engine_unit.sv
